// ===== sv/mrdd_pkg.sv =====
// ----------------------------------------------------------------------------
// mrdd_pkg
// shared codes, widths and types of the multi-resource deadlock detector
// ----------------------------------------------------------------------------
`default_nettype none

package mrdd_pkg;

    // default sizes of the stores
    localparam int MAX_PROCESSES_DEF = 16;
    localparam int MAX_RESOURCES_DEF = 8;

    // field widths
    localparam int KIND_W   = 2;
    localparam int PIDX_W   = 4;
    localparam int RIDX_W   = 3;
    localparam int AMOUNT_W = 8;
    localparam int AV_W     = 13;
    localparam int RIDX_OUT_W = 4;

    // saturation limits of an available value
    localparam int AV_MIN = -4096;
    localparam int AV_MAX = 4095;

    // input item kinds
    localparam logic [KIND_W-1:0] KIND_EXIST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REQ   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd3;

    // result kinds
    localparam logic RKIND_STATUS = 1'b0;
    localparam logic RKIND_AVAIL  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_PCOUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RCOUNT = 2'd1;

    // configuration widths and reset values
    localparam int PCOUNT_W = 5;
    localparam int RCOUNT_W = 4;
    localparam logic [PCOUNT_W-1:0] PCOUNT_RST = 5'd16;
    localparam logic [RCOUNT_W-1:0] RCOUNT_RST = 4'd8;

    // status of the shared add/subtract unit
    typedef struct packed {
        logic                   neg;
        logic signed [AV_W-1:0] sat;
    } alu_stat_t;

endpackage

`default_nettype wire

// ===== sv/mrdd_ram.sv =====
// ----------------------------------------------------------------------------
// mrdd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mrdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/mrdd_alu.sv =====
// ----------------------------------------------------------------------------
// mrdd_alu
// shared add/subtract unit with sign flag and 13-bit saturation
// ----------------------------------------------------------------------------
`default_nettype none

module mrdd_alu
    import mrdd_pkg::*;
#(
    parameter int ACC_W = 14
) (
    input  wire logic signed [ACC_W-1:0]    a,
    input  wire logic        [AMOUNT_W-1:0] b,
    input  wire logic                       sub,
    output logic signed      [ACC_W-1:0]    sum,
    output alu_stat_t                       stat
);

    localparam logic signed [ACC_W-1:0] LO = ACC_W'(AV_MIN);
    localparam logic signed [ACC_W-1:0] HI = ACC_W'(AV_MAX);

    logic signed [ACC_W-1:0] b_ext;

    assign b_ext = signed'(ACC_W'(b));
    assign sum   = sub ? (a - b_ext) : (a + b_ext);

    always_comb
    begin
        stat.neg = sum[ACC_W-1];
        if (sum < LO)
        begin
            stat.sat = AV_W'(LO);
        end
        else if (sum > HI)
        begin
            stat.sat = AV_W'(HI);
        end
        else
        begin
            stat.sat = sum[AV_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== sv/multi_resource_deadlock_detector_core.sv =====
// ----------------------------------------------------------------------------
// multi_resource_deadlock_detector_core
// deadlock detection over several resource types with a shared adder
// ----------------------------------------------------------------------------
// load beats (existing, allocation, request) are accepted back to back while
// idle; a run beat keeps busy high through the column sums, then per pass a
// select state for every process and, for an unfinished one, request checks
// up to the first misfit and, if all fit, the allocation return (at most np+1
// passes), then a status result per process and an available result per
// resource; every ram read has a read state and a use state on the shared adder
// results come one per cycle on result_valid and cannot be held off
// reset clears the sequencer, available values and finish marks and sets the
// counts to 16 and 8; the matrices and existing vector keep whatever was written
`default_nettype none

module multi_resource_deadlock_detector_core
    import mrdd_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = MAX_RESOURCES_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // command channel
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [KIND_W-1:0]       kind,
    input  wire logic [PIDX_W-1:0]       process_index,
    input  wire logic [RIDX_W-1:0]       resource_index,
    input  wire logic [AMOUNT_W-1:0]     amount,
    // configuration channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    // result channel
    output logic                         result_valid,
    output logic                         result_kind,
    output logic [PIDX_W-1:0]            result_index,
    output logic                         deadlocked,
    output logic signed [AV_W-1:0]       available_value,
    output logic                         last
);

    // sizes derived from the store dimensions
    localparam int PW    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // wide enough for existing minus the full column sum
    localparam int ACC_W = 10 + $clog2(MAX_PROCESSES);

    // sequencer codes
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SUM_RD  = 4'd1;
    localparam logic [3:0] ST_SUM_USE = 4'd2;
    localparam logic [3:0] ST_PSEL    = 4'd3;
    localparam logic [3:0] ST_CHK_RD  = 4'd4;
    localparam logic [3:0] ST_CHK_USE = 4'd5;
    localparam logic [3:0] ST_ADD_RD  = 4'd6;
    localparam logic [3:0] ST_ADD_USE = 4'd7;
    localparam logic [3:0] ST_OUT_P   = 4'd8;
    localparam logic [3:0] ST_OUT_R   = 4'd9;

    // control state
    logic [3:0]          state_reg, state_next;
    logic [PW-1:0]       p_reg, p_next;
    logic [RW-1:0]       r_reg, r_next;
    logic                changed_reg, changed_next;
    logic [PCOUNT_W-1:0] pcount_reg;
    logic [RCOUNT_W-1:0] rcount_reg;
    logic signed [AV_W-1:0] avail_reg [MAX_RESOURCES];
    logic signed [AV_W-1:0] avail_next [MAX_RESOURCES];
    logic [MAX_PROCESSES-1:0] fin_reg, fin_next;

    // payload registers
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [AMOUNT_W-1:0]     exist_reg [MAX_RESOURCES];

    // output registers
    logic                   rv_reg, rv_next;
    logic                   rk_reg, rk_next;
    logic [PIDX_W-1:0]      ri_reg, ri_next;
    logic                   dl_reg, dl_next;
    logic signed [AV_W-1:0] av_reg, av_next;
    logic                   last_reg, last_next;

    // beat decode
    logic        accept;
    logic        run_go;
    logic [31:0] pi_ext, ri_ext, wr_lin, rd_lin, p_ext, r_ext;
    logic        p_in_range, r_in_range;
    logic        exist_we, alloc_we, req_we;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [AMOUNT_W-1:0] alloc_rdata, req_rdata;

    // active counts, clamped
    logic [31:0]   pc_ext, rc_ext, np_lin, nr_lin;
    logic [PW-1:0] np_last;
    logic [RW-1:0] nr_last;
    logic          p_end, r_end;

    // shared adder
    logic signed [ACC_W-1:0]    alu_a;
    logic        [AMOUNT_W-1:0] alu_b;
    logic                       alu_sub;
    logic signed [ACC_W-1:0]    alu_sum;
    alu_stat_t                  alu_stat;
    logic signed [AV_W-1:0]     avail_cur;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign run_go    = accept && (kind == KIND_RUN);

    // load addressing; out-of-range indexes are dropped
    assign pi_ext     = 32'(process_index);
    assign ri_ext     = 32'(resource_index);
    assign p_in_range = (pi_ext < 32'(MAX_PROCESSES));
    assign r_in_range = (ri_ext < 32'(MAX_RESOURCES));
    assign wr_lin     = pi_ext * 32'(MAX_RESOURCES) + ri_ext;
    assign wr_addr    = wr_lin[AW-1:0];
    assign exist_we   = accept && (kind == KIND_EXIST) && r_in_range;
    assign alloc_we   = accept && (kind == KIND_ALLOC) && p_in_range && r_in_range;
    assign req_we     = accept && (kind == KIND_REQ) && p_in_range && r_in_range;

    // walk addressing, both matrices read at the same entry
    assign p_ext   = 32'(p_reg);
    assign r_ext   = 32'(r_reg);
    assign rd_lin  = p_ext * 32'(MAX_RESOURCES) + r_ext;
    assign rd_addr = rd_lin[AW-1:0];

    // zero count means one, too large a count means the maximum
    always_comb
    begin
        pc_ext = 32'(pcount_reg);
        rc_ext = 32'(rcount_reg);
        if (pc_ext == 32'd0)
        begin
            np_lin = 32'd0;
        end
        else if (pc_ext > 32'(MAX_PROCESSES))
        begin
            np_lin = 32'(MAX_PROCESSES - 1);
        end
        else
        begin
            np_lin = pc_ext - 32'd1;
        end
        if (rc_ext == 32'd0)
        begin
            nr_lin = 32'd0;
        end
        else if (rc_ext > 32'(MAX_RESOURCES))
        begin
            nr_lin = 32'(MAX_RESOURCES - 1);
        end
        else
        begin
            nr_lin = rc_ext - 32'd1;
        end
    end

    assign np_last = np_lin[PW-1:0];
    assign nr_last = nr_lin[RW-1:0];
    assign p_end   = (p_reg == np_last);
    assign r_end   = (r_reg == nr_last);

    mrdd_ram #(
        .WIDTH (AMOUNT_W),
        .DEPTH (DEPTH)
    ) u_alloc_ram (
        .clk   (clk),
        .we    (alloc_we),
        .waddr (wr_addr),
        .wdata (amount),
        .raddr (rd_addr),
        .rdata (alloc_rdata)
    );

    mrdd_ram #(
        .WIDTH (AMOUNT_W),
        .DEPTH (DEPTH)
    ) u_req_ram (
        .clk   (clk),
        .we    (req_we),
        .waddr (wr_addr),
        .wdata (amount),
        .raddr (rd_addr),
        .rdata (req_rdata)
    );

    assign avail_cur = avail_reg[r_reg];

    // operand selection for the shared adder
    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = alloc_rdata;
        alu_sub = 1'b1;
        case (state_reg)
            ST_CHK_USE:
            begin
                // request fits when available minus request stays non-negative
                alu_a   = ACC_W'(avail_cur);
                alu_b   = req_rdata;
                alu_sub = 1'b1;
            end
            ST_ADD_USE:
            begin
                // finished process hands its allocation back
                alu_a   = ACC_W'(avail_cur);
                alu_b   = alloc_rdata;
                alu_sub = 1'b0;
            end
            default:
            begin
                // column sum: existing minus each allocation
                alu_a   = acc_reg;
                alu_b   = alloc_rdata;
                alu_sub = 1'b1;
            end
        endcase
    end

    mrdd_alu #(
        .ACC_W (ACC_W)
    ) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .sub  (alu_sub),
        .sum  (alu_sum),
        .stat (alu_stat)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        p_next       = p_reg;
        r_next       = r_reg;
        changed_next = changed_reg;
        acc_next     = acc_reg;
        avail_next   = avail_reg;
        fin_next     = fin_reg;
        rv_next      = 1'b0;
        rk_next      = rk_reg;
        ri_next      = ri_reg;
        dl_next      = dl_reg;
        av_next      = av_reg;
        last_next    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (run_go)
                begin
                    p_next     = '0;
                    r_next     = '0;
                    fin_next   = '0;
                    state_next = ST_SUM_RD;
                end
            end

            ST_SUM_RD:
            begin
                // first row of a column seeds the accumulator with existing
                if (p_reg == '0)
                begin
                    acc_next = signed'(ACC_W'(exist_reg[r_reg]));
                end
                state_next = ST_SUM_USE;
            end

            ST_SUM_USE:
            begin
                acc_next = alu_sum;
                if (p_end)
                begin
                    avail_next[r_reg] = alu_stat.sat;
                    p_next = '0;
                    if (r_end)
                    begin
                        r_next       = '0;
                        changed_next = 1'b0;
                        state_next   = ST_PSEL;
                    end
                    else
                    begin
                        r_next     = r_reg + 1'b1;
                        state_next = ST_SUM_RD;
                    end
                end
                else
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = ST_SUM_RD;
                end
            end

            ST_PSEL:
            begin
                r_next = '0;
                if (fin_reg[p_reg])
                begin
                    // already finished, move on
                    if (!p_end)
                    begin
                        p_next = p_reg + 1'b1;
                    end
                    else if (changed_reg)
                    begin
                        p_next       = '0;
                        changed_next = 1'b0;
                    end
                    else
                    begin
                        p_next     = '0;
                        state_next = ST_OUT_P;
                    end
                end
                else
                begin
                    state_next = ST_CHK_RD;
                end
            end

            ST_CHK_RD:
            begin
                state_next = ST_CHK_USE;
            end

            ST_CHK_USE:
            begin
                if (alu_stat.neg)
                begin
                    // request does not fit, process stays unfinished this pass
                    r_next = '0;
                    if (!p_end)
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = ST_PSEL;
                    end
                    else if (changed_reg)
                    begin
                        p_next       = '0;
                        changed_next = 1'b0;
                        state_next   = ST_PSEL;
                    end
                    else
                    begin
                        p_next     = '0;
                        state_next = ST_OUT_P;
                    end
                end
                else if (r_end)
                begin
                    r_next     = '0;
                    state_next = ST_ADD_RD;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_CHK_RD;
                end
            end

            ST_ADD_RD:
            begin
                state_next = ST_ADD_USE;
            end

            ST_ADD_USE:
            begin
                avail_next[r_reg] = alu_stat.sat;
                if (r_end)
                begin
                    fin_next[p_reg] = 1'b1;
                    r_next          = '0;
                    if (!p_end)
                    begin
                        p_next       = p_reg + 1'b1;
                        changed_next = 1'b1;
                    end
                    else
                    begin
                        // a pass that marked something is followed by another
                        p_next       = '0;
                        changed_next = 1'b0;
                    end
                    state_next = ST_PSEL;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_ADD_RD;
                end
            end

            ST_OUT_P:
            begin
                rv_next   = 1'b1;
                rk_next   = RKIND_STATUS;
                ri_next   = p_ext[PIDX_W-1:0];
                dl_next   = !fin_reg[p_reg];
                av_next   = '0;
                last_next = 1'b0;
                if (p_end)
                begin
                    p_next     = '0;
                    r_next     = '0;
                    state_next = ST_OUT_R;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                end
            end

            ST_OUT_R:
            begin
                rv_next   = 1'b1;
                rk_next   = RKIND_AVAIL;
                ri_next   = r_ext[PIDX_W-1:0];
                dl_next   = 1'b0;
                av_next   = avail_cur;
                last_next = r_end;
                if (r_end)
                begin
                    r_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    r_next = r_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            p_reg       <= '0;
            r_reg       <= '0;
            changed_reg <= 1'b0;
            fin_reg     <= '0;
            rv_reg      <= 1'b0;
            last_reg    <= 1'b0;
            for (int i = 0; i < MAX_RESOURCES; i++)
            begin
                avail_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            p_reg       <= p_next;
            r_reg       <= r_next;
            changed_reg <= changed_next;
            fin_reg     <= fin_next;
            rv_reg      <= rv_next;
            last_reg    <= last_next;
            avail_reg   <= avail_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= PCOUNT_RST;
            rcount_reg <= RCOUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PCOUNT: pcount_reg <= cfg_data[PCOUNT_W-1:0];
                CFG_RCOUNT: rcount_reg <= cfg_data[RCOUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rk_reg  <= rk_next;
        ri_reg  <= ri_next;
        dl_reg  <= dl_next;
        av_reg  <= av_next;
        if (exist_we)
        begin
            exist_reg[ri_ext[RW-1:0]] <= amount;
        end
    end

    assign result_valid    = rv_reg;
    assign result_kind     = rk_reg;
    assign result_index    = ri_reg;
    assign deadlocked      = dl_reg;
    assign available_value = av_reg;
    assign last            = last_reg;

endmodule

`default_nettype wire

// ===== sv/mrdd_checker.sv =====
// ----------------------------------------------------------------------------
// mrdd_checker
// port-level checks of the deadlock detector, bound to the detector core
// ----------------------------------------------------------------------------
`default_nettype none

module mrdd_checker
    import mrdd_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic [KIND_W-1:0]     kind,
    input wire logic                  result_valid,
    input wire logic                  result_kind,
    input wire logic                  deadlocked,
    input wire logic signed [AV_W-1:0] available_value,
    input wire logic                  last
);

    // a run beat always keeps the block busy in the next cycle
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_RUN)) |=> busy)
        else $error("run beat accepted but block not busy");

    // results of a run come without gaps up to the last one
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> result_valid)
        else $error("gap inside a run's results");

    // last only ever marks a final available result
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> (result_valid && (result_kind == RKIND_AVAIL)))
        else $error("last on a result that is not a final available value");

    // unused fields stay zero
    a_unused: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result_kind == RKIND_STATUS) ? (available_value == '0)
                                                         : (deadlocked == 1'b0)))
        else $error("unused result field not zero");

endmodule

bind multi_resource_deadlock_detector_core mrdd_checker u_mrdd_checker (.*);

`default_nettype wire
